// ----- hw/rtl/page_framebuffer_glyph_writer_top_macros.svh -----
`ifndef PAGE_FRAMEBUFFER_GLYPH_WRITER_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_GLYPH_WRITER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFGW_ASSERT_NOW(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("pfgw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFGW_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("pfgw assertion failed");

`endif

// ----- hw/rtl/pfgw_pkg.sv -----
package pfgw_pkg;

	localparam int PAGES_DEF   = 8;
	localparam int COLUMNS_DEF = 128;

	// Stream payload layout.
	localparam int DATA_W = 48;
	localparam int USER_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W = 8;

	localparam int OX_LSB   = 0;
	localparam int OY_LSB   = 8;
	localparam int GC_LSB   = 16;
	localparam int GR_LSB   = 23;
	localparam int BITS_LSB = 26;
	localparam int REV_LSB  = 34;
	localparam int RP_LSB   = 35;
	localparam int RC_LSB   = 38;

	localparam logic [USER_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [USER_W-1:0] KIND_WRITE = 2'd1;
	localparam logic [USER_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'b1;

	localparam logic [7:0] GLYPH_WIDTH_RST  = 8'd6;
	localparam logic [6:0] GLYPH_HEIGHT_RST = 7'd8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_LO,
		ST_WR_HI,
		ST_RD_ADDR,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic wr_lo;
		logic wr_hi;
		logic rd_hi;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic ok_lo;
		logic ok_hi;
		logic out_busy;
	} status_t;

endpackage

// ----- hw/rtl/pfgw_ctrl.sv -----
module pfgw_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic [pfgw_pkg::USER_W-1:0]    s_tuser,
	output logic                           s_tready,
	input  pfgw_pkg::status_t              status,
	output pfgw_pkg::cmd_t                 cmd
);
	import pfgw_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						KIND_CLEAR: state_nxt = ST_CLEAR;
						KIND_WRITE: state_nxt = ST_WR_RD;
						KIND_READ:  state_nxt = ST_RD_ADDR;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_WR_RD:   state_nxt = ST_WR_LO;
			ST_WR_LO:   state_nxt = status.ok_hi ? ST_WR_HI : ST_IDLE;
			ST_WR_HI:   state_nxt = ST_IDLE;
			ST_RD_ADDR: state_nxt = ST_RD_OUT;
			ST_RD_OUT: begin
				if (!status.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_WR_RD: ;
			ST_WR_LO: begin
				cmd.wr_lo = status.ok_lo;
				cmd.rd_hi = 1'b1;
			end
			ST_WR_HI:   cmd.wr_hi = 1'b1;
			ST_RD_ADDR: ;
			ST_RD_OUT:  cmd.out_load = !status.out_busy;
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/pfgw_datapath.sv -----
module pfgw_datapath #(
	parameter int PAGES   = pfgw_pkg::PAGES_DEF,
	parameter int COLUMNS = pfgw_pkg::COLUMNS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pfgw_pkg::DATA_W-1:0]      s_tdata,
	input  logic [pfgw_pkg::USER_W-1:0]      s_tuser,
	input  logic                             cfg_we,
	input  logic [pfgw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfgw_pkg::CFG_W-1:0]       cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,
	input  pfgw_pkg::cmd_t                   cmd,
	output pfgw_pkg::status_t                status
);
	import pfgw_pkg::*;

	localparam int DEPTH  = PAGES * COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [7:0] mem [DEPTH];

	logic [7:0]        glyph_width_q;
	logic [6:0]        glyph_height_q;
	logic [ADDR_W-1:0] clr_ptr_q;
	logic [ADDR_W-1:0] addr_lo_q;
	logic [ADDR_W-1:0] addr_hi_q;
	logic [15:0]       mask_q;
	logic [15:0]       data_q;
	logic              ok_lo_q;
	logic              ok_hi_q;
	logic [7:0]        rdata_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	// Input fields.
	logic [7:0] origin_x;
	logic [7:0] origin_y;
	logic [6:0] glyph_col;
	logic [2:0] glyph_row_byte;
	logic [7:0] glyph_bits;
	logic       reversed;
	logic [2:0] read_page;
	logic [6:0] read_col;

	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic [3:0]  full_rows;
	logic [2:0]  part_bits;
	logic        row_full;
	logic        row_part;
	logic        do_write;
	logic [3:0]  bit_len;
	logic [7:0]  len_mask;
	logic [15:0] mask16;
	logic [15:0] data16;
	logic [4:0]  page_lo;
	logic [5:0]  page_hi;
	logic        col_ok;
	logic        wr_ok_lo;
	logic        wr_ok_hi;
	logic        rd_ok;
	logic [ADDR_W-1:0] wr_addr_lo;
	logic [ADDR_W-1:0] wr_addr_hi;
	logic [ADDR_W-1:0] rd_addr;

	logic [ADDR_W-1:0] mem_raddr;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_we;
	logic [7:0]        merge_mask;
	logic [7:0]        merge_data;

	always_comb begin
		origin_x       = s_tdata[OX_LSB +: 8];
		origin_y       = s_tdata[OY_LSB +: 8];
		glyph_col      = s_tdata[GC_LSB +: 7];
		glyph_row_byte = s_tdata[GR_LSB +: 3];
		glyph_bits     = s_tdata[BITS_LSB +: 8];
		reversed       = s_tdata[REV_LSB];
		read_page      = s_tdata[RP_LSB +: 3];
		read_col       = s_tdata[RC_LSB +: 7];

		pos_x = origin_x + {1'b0, glyph_col};
		pos_y = origin_y + {2'b00, glyph_row_byte, 3'b000};

		full_rows = glyph_height_q[6:3];
		part_bits = glyph_height_q[2:0];
		row_full  = {1'b0, glyph_row_byte} < full_rows;
		row_part  = ({1'b0, glyph_row_byte} == full_rows) && (part_bits != 3'd0);
		do_write  = ({1'b0, glyph_col} < glyph_width_q) && (row_full || row_part);

		// The partial row byte writes only the low glyph_height mod 8 bits, the top pixel rows.
		bit_len  = row_full ? 4'd8 : {1'b0, part_bits};
		len_mask = 8'hFF >> (4'd8 - bit_len);
		mask16   = {8'h00, len_mask} << pos_y[2:0];
		data16   = {8'h00, (reversed ? ~glyph_bits : glyph_bits)} << pos_y[2:0];

		page_lo  = pos_y[7:3];
		page_hi  = {1'b0, page_lo} + 6'd1;
		col_ok   = {1'b0, pos_x} < 9'(COLUMNS);
		wr_ok_lo = do_write && col_ok && ({1'b0, page_lo} < 6'(PAGES));
		wr_ok_hi = do_write && col_ok && (mask16[15:8] != 8'h00) && (page_hi < 6'(PAGES));
		rd_ok    = ({3'b000, read_page} < 6'(PAGES)) && ({2'b00, read_col} < 9'(COLUMNS));

		wr_addr_lo = ADDR_W'(32'(page_lo) * COLUMNS + 32'(pos_x));
		wr_addr_hi = ADDR_W'(32'(page_hi) * COLUMNS + 32'(pos_x));
		rd_addr    = ADDR_W'(32'(read_page) * COLUMNS + 32'(read_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= GLYPH_WIDTH_RST;
			glyph_height_q <= GLYPH_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_GLYPH_WIDTH) begin
				glyph_width_q <= cfg_data;
			end else begin
				glyph_height_q <= cfg_data[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_ptr_q <= (clr_ptr_q == LAST_ADDR) ? '0 : clr_ptr_q + 1'b1;
		end
	end

	// The low address register also carries the address of a read request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_lo_q <= 1'b0;
			ok_hi_q <= 1'b0;
		end else if (cmd.capture) begin
			if (s_tuser == KIND_READ) begin
				ok_lo_q <= rd_ok;
				ok_hi_q <= 1'b0;
			end else begin
				ok_lo_q <= wr_ok_lo;
				ok_hi_q <= wr_ok_hi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_lo_q <= (s_tuser == KIND_READ) ? rd_addr : wr_addr_lo;
			addr_hi_q <= wr_addr_hi;
			mask_q    <= mask16;
			data_q    <= data16;
		end
	end

	always_comb begin
		merge_mask = cmd.wr_hi ? mask_q[15:8] : mask_q[7:0];
		merge_data = cmd.wr_hi ? data_q[15:8] : data_q[7:0];
		mem_raddr  = cmd.rd_hi ? addr_hi_q : addr_lo_q;
		mem_we     = cmd.clr_wr || cmd.wr_lo || cmd.wr_hi;
		if (cmd.clr_wr) begin
			mem_waddr = clr_ptr_q;
			mem_wdata = 8'h00;
		end else begin
			mem_waddr = cmd.wr_hi ? addr_hi_q : addr_lo_q;
			mem_wdata = (rdata_q & ~merge_mask) | (merge_data & merge_mask);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= ok_lo_q ? rdata_q : 8'h00;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		status.clr_last = (clr_ptr_q == LAST_ADDR);
		status.ok_lo    = ok_lo_q;
		status.ok_hi    = ok_hi_q;
		status.out_busy = out_valid_q && !m_tready;
	end

endmodule

// ----- hw/rtl/page_framebuffer_glyph_writer_top.sv -----
// Write request: each page byte is read, then written back merged with the glyph bits; a byte
// that spans two pages does the low page and then the high page in turn, then is ready again.
// Read request: read, then loaded into the output register once it is free; ready again after the load.
// Clear request: one buffer byte a cycle, ready again once the whole buffer is zero.
// Reset is asynchronous and active low; afterwards the whole buffer is swept to zero,
// during which configuration writes are taken but no request.
`include "page_framebuffer_glyph_writer_top_macros.svh"

module page_framebuffer_glyph_writer_top #(
	parameter int PAGES   = pfgw_pkg::PAGES_DEF,
	parameter int COLUMNS = pfgw_pkg::COLUMNS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// origin_x, origin_y, glyph_col, glyph_row_byte, glyph_bits, reversed,
	// read_page, read_col, zero pad
	input  logic [pfgw_pkg::DATA_W-1:0]      s_tdata,
	// kind
	input  logic [pfgw_pkg::USER_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_byte
	output logic [7:0]                       m_tdata,
	input  logic                             cfg_we,
	input  logic [pfgw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfgw_pkg::CFG_W-1:0]       cfg_data
);
	import pfgw_pkg::*;

	cmd_t    cmd;
	status_t status;

	pfgw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pfgw_datapath #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

	`PFGW_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, cmd.clr_wr, !s_tready)
	`PFGW_ASSERT_NOW(a_no_accept_in_rmw, clk, arst_n, cmd.wr_lo || cmd.wr_hi, !s_tready)
	`PFGW_ASSERT_NOW(a_result_from_load, clk, arst_n, $rose(m_tvalid), $past(cmd.out_load))
	`PFGW_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.out_load, m_tvalid)

endmodule
